// ===== sv/pvp_pkg.sv =====
// Shared constants and types for the perspective vertex projector.
`timescale 1ns / 1ps
package pvp_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned NumRegs   = 8;
  localparam int unsigned RegW      = 64;
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned FracBitsD = 16;

  typedef logic [RegW-1:0] mat_reg_t;

  // Matrix register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegRow0Cols01 = 4'd0,
    RegRow0Cols23 = 4'd1,
    RegRow1Cols01 = 4'd2,
    RegRow1Cols23 = 4'd3,
    RegRow2Cols01 = 4'd4,
    RegRow2Cols23 = 4'd5,
    RegRow3Cols01 = 4'd6,
    RegRow3Cols23 = 4'd7
  } cfg_idx_e;

  // Identity matrix at the default fraction width
  localparam mat_reg_t MatReset [NumRegs] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  // Status that rides along with the three result lanes
  typedef struct packed {
    logic w_zero;
    logic overflow;
  } res_flags_t;

endpackage

// ===== sv/perspective_vertex_project.sv =====
// Top level of the perspective vertex projector: config, pipeline control, lanes.
//
// Usage: each request on the s_axis channel carries one vertex (x, y, z in
// signed fixed point, w taken as one). The vertex is multiplied by a 4x4
// matrix held in eight 64-bit registers written over the cfg channel
// (cfg_index_i selects the register, indexes past seven are dropped;
// cfg_ready_o is always high). x, y, z are then divided by w, truncated
// toward zero and saturated; on w == 0 they pass through and w_zero is set.
// Results leave on m_axis, tuser carries w_zero and overflow.
// The pipeline has three transform stages, one sign stage, one restoring
// divider stage per quotient bit (32 + FRAC_BITS of them) and the output
// register. One vertex enters per clock unless the output stalls. The whole
// pipeline advances on one enable; when the receiver stalls with a result
// waiting, every stage holds and s_axis_tready drops. Reset clears the valid
// bits and loads the identity matrix. Write the matrix only while the
// pipeline is empty.
`timescale 1ns / 1ps
module perspective_vertex_project #(
  parameter int unsigned FRAC_BITS = pvp_pkg::FracBitsD
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [95:0]                    s_axis_tdata,  // in_x, in_y, in_z
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [95:0]                    m_axis_tdata,  // proj_x, proj_y, proj_z
  output logic [1:0]                     m_axis_tuser,  // w_zero, overflow
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pvp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  pvp_pkg::mat_reg_t              cfg_data_i
);
  import pvp_pkg::*;

  localparam int unsigned Lat = 3 + 1 + CoordW + FRAC_BITS + 1;

  mat_reg_t           mat_q [NumRegs];
  logic [Lat-1:0]     vld_q;
  logic [Lat-1:0]     vld_d;
  logic               en;
  logic signed [31:0] h     [4];
  logic               xf_ovf;
  logic [Lat-4:0]     ovf_dly_q;
  logic signed [31:0] res   [3];
  logic [2:0]         lane_wz;
  logic [2:0]         lane_ovf;
  res_flags_t         flags;

  assign en            = !vld_q[Lat-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  // Load matrix registers, drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= MatReset;
    end else if (cfg_valid_i && (cfg_index_i <= RegRow3Cols23)) begin
      mat_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  // Advance valid bits with the data
  assign vld_d = {vld_q[Lat-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  pvp_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (s_axis_tdata[31:0]),
    .y_i   (s_axis_tdata[63:32]),
    .z_i   (s_axis_tdata[95:64]),
    .mat_i (mat_q),
    .h_o   (h),
    .ovf_o (xf_ovf)
  );

  // Hold the transform overflow alongside the divider lanes
  always_ff @(posedge clk_i) begin
    if (en) begin
      ovf_dly_q <= {ovf_dly_q[Lat-5:0], xf_ovf};
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    pvp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (h[l]),
      .den_i (h[3]),
      .res_o (res[l]),
      .wz_o  (lane_wz[l]),
      .ovf_o (lane_ovf[l])
    );
  end

  assign flags.w_zero   = lane_wz[0];
  assign flags.overflow = ovf_dly_q[Lat-4] || (|lane_ovf);

  assign m_axis_tvalid = vld_q[Lat-1];
  assign m_axis_tdata  = {res[2], res[1], res[0]};
  assign m_axis_tuser  = {flags.overflow, flags.w_zero};

  // A waiting result must stop the input side
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // Frozen pipeline keeps its valid bits
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid bits moved during stall");

  // All lanes agree on a zero divisor
  a_lane_wz_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (lane_wz == 3'b000 || lane_wz == 3'b111))
    else $error("divider lanes disagree on zero w");

endmodule

// ===== sv/pvp_xform.sv =====
// Three-stage 4x4 matrix transform: products, sums, round and saturate.
`timescale 1ns / 1ps
module pvp_xform #(
  parameter int unsigned FRAC_BITS = pvp_pkg::FracBitsD
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [31:0]            x_i,
  input  logic signed [31:0]            y_i,
  input  logic signed [31:0]            z_i,
  input  pvp_pkg::mat_reg_t             mat_i [pvp_pkg::NumRegs],
  output logic signed [31:0]            h_o   [4],
  output logic                          ovf_o
);
  import pvp_pkg::*;

  logic signed [63:0] prod_q [4][3];
  logic signed [31:0] t1_q   [4];
  logic signed [65:0] sum_q  [4];
  logic signed [31:0] t2_q   [4];
  logic signed [31:0] v      [3];
  logic signed [66:0] full   [4];
  logic signed [31:0] h_d    [4];
  logic               ovf_d;

  assign v[0] = x_i;
  assign v[1] = y_i;
  assign v[2] = z_i;

  // Form all twelve products and pick up the translation row
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 4; c++) begin
        for (int i = 0; i < 3; i++) begin
          prod_q[c][i] <= 64'(v[i]) *
                          64'($signed(mat_i[i*2 + c/2][(c%2)*32 +: 32]));
        end
        t1_q[c] <= $signed(mat_i[6 + c/2][(c%2)*32 +: 32]);
      end
    end
  end

  // Add the products exactly
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 4; c++) begin
        sum_q[c] <= 66'(prod_q[c][0]) + 66'(prod_q[c][1]) + 66'(prod_q[c][2]);
        t2_q[c]  <= t1_q[c];
      end
    end
  end

  // Round toward minus infinity, add translation, saturate
  always_comb begin
    ovf_d = 1'b0;
    for (int c = 0; c < 4; c++) begin
      full[c] = 67'(sum_q[c] >>> FRAC_BITS) + 67'(t2_q[c]);
      if (full[c] > 67'sd2147483647) begin
        h_d[c] = 32'sh7FFF_FFFF;
        ovf_d  = 1'b1;
      end else if (full[c] < -67'sd2147483648) begin
        h_d[c] = 32'sh8000_0000;
        ovf_d  = 1'b1;
      end else begin
        h_d[c] = full[c][31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_o   <= h_d;
      ovf_o <= ovf_d;
    end
  end

endmodule

// ===== sv/pvp_div.sv =====
// Pipelined restoring divider lane, one quotient bit per stage.
`timescale 1ns / 1ps
module pvp_div #(
  parameter int unsigned FRAC_BITS = pvp_pkg::FracBitsD
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic signed [31:0] res_o,
  output logic               wz_o,
  output logic               ovf_o
);
  import pvp_pkg::*;

  localparam int unsigned DW = CoordW + FRAC_BITS;

  logic [31:0]    dmag_q [DW+1];
  logic [32:0]    rem_q  [DW+1];
  logic [DW-1:0]  nd_q   [DW+1];
  logic [DW-1:0]  quo_q  [DW+1];
  logic           neg_q  [DW+1];
  logic           wz_q   [DW+1];
  logic [31:0]    num_q  [DW+1];
  logic [31:0]    nmag;
  logic [31:0]    dmag;
  logic signed [31:0] res_d;
  logic           ovf_d;

  assign nmag = num_i[31] ? 32'(-num_i) : num_i;
  assign dmag = den_i[31] ? 32'(-den_i) : den_i;

  // Take magnitudes and signs
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dmag_q[0] <= dmag;
      rem_q[0]  <= '0;
      nd_q[0]   <= {nmag, {FRAC_BITS{1'b0}}};
      quo_q[0]  <= '0;
      neg_q[0]  <= num_i[31] ^ den_i[31];
      wz_q[0]   <= (den_i == '0);
      num_q[0]  <= num_i;
    end
  end

  // One trial subtraction per stage
  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [32:0] trial;
    logic        take;
    assign trial = {rem_q[k][31:0], nd_q[k][DW-1]};
    assign take  = (trial >= {1'b0, dmag_q[k]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= take ? (trial - {1'b0, dmag_q[k]}) : trial;
        nd_q[k+1]   <= {nd_q[k][DW-2:0], 1'b0};
        quo_q[k+1]  <= {quo_q[k][DW-2:0], take};
        dmag_q[k+1] <= dmag_q[k];
        neg_q[k+1]  <= neg_q[k];
        wz_q[k+1]   <= wz_q[k];
        num_q[k+1]  <= num_q[k];
      end
    end
  end

  // Apply sign, saturate, or pass the numerator through on zero divisor
  always_comb begin
    ovf_d = 1'b0;
    if (wz_q[DW]) begin
      res_d = num_q[DW];
    end else if (neg_q[DW]) begin
      if (quo_q[DW] > DW'(33'h0_8000_0000)) begin
        res_d = 32'sh8000_0000;
        ovf_d = 1'b1;
      end else begin
        res_d = 32'(-quo_q[DW]);
      end
    end else if (quo_q[DW] > DW'(32'h7FFF_FFFF)) begin
      res_d = 32'sh7FFF_FFFF;
      ovf_d = 1'b1;
    end else begin
      res_d = quo_q[DW][31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= res_d;
      wz_o  <= wz_q[DW];
      ovf_o <= ovf_d;
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the perspective vertex projector.
`timescale 1ns / 1ps
module tb_top;
  import pvp_pkg::*;

  localparam int unsigned FracBits = FracBitsD;
  localparam logic [CfgIdxW-1:0] RegUnmapped = 4'd12;  // no register behind it
  localparam int unsigned DrainCycles = FracBits + 60;

  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } vertex_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        w_zero;
    logic        overflow;
  } proj_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;  // in_x, in_y, in_z
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;       // proj_x, proj_y, proj_z
  logic [1:0] m_axis_tuser;        // w_zero, overflow
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  mat_reg_t cfg_data_i = '0;

  perspective_vertex_project #(.FRAC_BITS(FracBits)) i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  mat_reg_t matrix [NumRegs];
  vertex_t  vertex_q [$];
  proj_t    proj_q [$];
  int unsigned queued_cnt = 0;
  int unsigned result_cnt = 0;
  int unsigned err_cnt = 0;
  bit          was_taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned gap_max = 0;
  int unsigned stall_pct = 0;

  // Saturate an exact value to signed 32 bits
  function automatic longint sat32(input logic signed [67:0] a, inout bit ovf);
    if (a > 68'sd2147483647) begin
      ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (a < -68'sd2147483648) begin
      ovf = 1'b1;
      return -64'sd2147483648;
    end
    return longint'(a);
  endfunction

  // Row vector times matrix, then divide by w
  function automatic proj_t project_vertex(input vertex_t v);
    longint coef [4][4];
    longint h [4];
    longint comp [3];
    logic signed [67:0] acc;
    logic [31:0] half;
    bit ovf;
    proj_t r;
    ovf = 1'b0;
    comp[0] = v.x;
    comp[1] = v.y;
    comp[2] = v.z;
    for (int row = 0; row < 4; row++) begin
      for (int col = 0; col < 4; col++) begin
        half = (col % 2) ? matrix[2*row + col/2][63:32] : matrix[2*row + col/2][31:0];
        coef[row][col] = longint'($signed(half));
      end
    end
    for (int col = 0; col < 4; col++) begin
      acc = '0;
      for (int i = 0; i < 3; i++) acc = acc + (comp[i] * coef[i][col]);
      acc = (acc >>> FracBits) + coef[3][col];
      h[col] = sat32(acc, ovf);
    end
    r.w_zero = (h[3] == 0);
    for (int i = 0; i < 3; i++) begin
      if (r.w_zero) acc = h[i];
      else acc = (h[i] * (64'sd1 <<< FracBits)) / h[3];
      comp[i] = sat32(acc, ovf);
    end
    r.x = comp[0][31:0];
    r.y = comp[1][31:0];
    r.z = comp[2][31:0];
    r.overflow = ovf;
    return r;
  endfunction

  // Accept vertices and record their projections
  always @(posedge clk_i) begin
    was_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) proj_q.push_back(project_vertex(s_axis_tdata));
  end

  // Drive vertices in bursts separated by gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || was_taken)) begin
      if (gap_left > 0 || vertex_q.size() == 0) begin
        s_axis_tvalid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= vertex_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Stall the result side
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    proj_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_cnt <= result_cnt + 1;
      if (proj_q.size() == 0) begin
        err_cnt <= err_cnt + 1;
        $display("%0t: result with no vertex pending, tdata=%h tuser=%b", $realtime,
                 m_axis_tdata, m_axis_tuser);
      end else begin
        e = proj_q.pop_front();
        if ({e.z, e.y, e.x} !== m_axis_tdata || {e.overflow, e.w_zero} !== m_axis_tuser) begin
          err_cnt <= err_cnt + 1;
          $display("%0t: mismatch exp x=%h y=%h z=%h wz=%b ovf=%b", $realtime,
                   e.x, e.y, e.z, e.w_zero, e.overflow);
          $display("%0t:          act x=%h y=%h z=%h wz=%b ovf=%b", $realtime,
                   m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                   m_axis_tuser[0], m_axis_tuser[1]);
        end
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input mat_reg_t val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx < NumRegs) matrix[idx[2:0]] = val;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic push_vertex(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    vertex_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    vertex_q.push_back(v);
    queued_cnt++;
  endtask

  task automatic wait_idle();
    wait (result_cnt == queued_cnt);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_word(input int unsigned mode);
    logic [31:0] w;
    case (mode)
      0: w = $urandom;
      1: w = $urandom_range(0, 32'h0004_0000);
      2: w = $urandom_range(0, 32'h0100_0000);
      default: w = $urandom_range(0, 3) + 32'h7FFF_FFFC;
    endcase
    if (mode != 0 && $urandom_range(0, 1)) w = -w;
    return w;
  endfunction

  // Load a random matrix; mostly well-scaled so divides give real values
  task automatic load_matrix(input int unsigned mode);
    for (int r = 0; r < NumRegs; r++)
      write_reg(cfg_idx_e'(r), {rand_word(mode), rand_word(mode)});
  endtask

  task automatic random_vertices(input int unsigned n, input int unsigned mode);
    int unsigned m;
    for (int unsigned i = 0; i < n; i++) begin
      m = ($urandom_range(0, 9) < 7) ? mode : $urandom_range(0, 3);
      push_vertex(rand_word(m), rand_word(m), rand_word(m));
    end
    wait_idle();
  endtask

  initial begin
    for (int r = 0; r < NumRegs; r++) matrix[r] = MatReset[r];
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Identity after reset: field extremes pass straight through
    push_vertex(32'h0, 32'h0, 32'h0);
    push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    push_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
    push_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    wait_idle();

    // Zero w: no divide, coordinates pass through
    write_reg(RegRow3Cols23, 64'h0);
    push_vertex(32'h0001_2345, 32'hFFFE_0000, 32'h7FFF_FFFF);
    push_vertex(32'h8000_0000, 32'h0, 32'h1);
    wait_idle();

    // Tiny negative w rounds to minus one ulp and still divides; a negative x gives a positive w
    write_reg(RegRow0Cols23, 64'hFFFF_FFFF_0000_0000);
    push_vertex(32'h1, 32'h0, 32'h0);
    push_vertex(32'h0001_0000, 32'h0, 32'h0);
    push_vertex(32'h8000_0000, 32'h4000_0000, 32'h0);
    wait_idle();

    // Extreme coefficients: sums and quotients saturate
    for (int r = 0; r < NumRegs; r++) write_reg(cfg_idx_e'(r), 64'h8000_0000_8000_0000);
    push_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_vertex(32'h7FFF_FFFF, 32'h0, 32'h1);
    push_vertex(32'h0, 32'h0, 32'h0);
    wait_idle();
    for (int r = 0; r < NumRegs; r++) write_reg(cfg_idx_e'(r), 64'h7FFF_FFFF_7FFF_FFFF);
    push_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_vertex(32'hFFFF_FFFF, 32'h0, 32'h0);
    wait_idle();

    // A write to an unmapped index leaves the matrix alone
    for (int r = 0; r < NumRegs; r++) write_reg(cfg_idx_e'(r), {$urandom, $urandom});
    write_reg(RegUnmapped, 64'h0);
    push_vertex(32'h0003_0000, 32'hFFFD_8000, 32'h0000_4000);
    push_vertex($urandom, $urandom, $urandom);
    wait_idle();

    // Random phases: vary matrix scale, sender gaps and receiver stalls
    for (int p = 0; p < 10; p++) begin
      gap_max   = (p % 3 == 0) ? 0 : $urandom_range(1, 6);
      stall_pct = (p % 4 == 1) ? 0 : $urandom_range(10, 70);
      load_matrix((p % 5 == 4) ? 0 : 1 + (p % 2));
      random_vertices(160, (p % 5 == 3) ? 0 : 1 + ((p + 1) % 2));
    end

    gap_max = 0;
    stall_pct = 0;
    repeat (DrainCycles) @(posedge clk_i);
    if (proj_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d results never arrived", $realtime, proj_q.size());
    end
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
